[hw/rtl/dbpec_pkg.sv]
// dbpec_pkg: shared types and constants for the page endian converter
// no dependencies

package dbpec_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PSIZE_W  = 17;

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONVERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_ONLY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd2;

    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 17'd4096;
    localparam logic [PSIZE_W-1:0] HDR_END     = 17'd26;
    localparam logic [PSIZE_W-1:0] TYPE_POS    = 17'd25;

    localparam logic [BYTE_W-1:0] T_HASH     = 8'd2;
    localparam logic [BYTE_W-1:0] T_HASH_UNS = 8'd13;
    localparam logic [BYTE_W-1:0] T_BINT     = 8'd3;
    localparam logic [BYTE_W-1:0] T_BLEAF    = 8'd5;
    localparam logic [BYTE_W-1:0] K_OVERFLOW = 8'd3;
    localparam logic [BYTE_W-1:0] K_KEYDATA  = 8'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] byte_addr;
        logic [BYTE_W-1:0] write_byte;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

[hw/rtl/dbpec_if.sv]
// dbpec_if: valid/ready channel carrying one payload
// depends on dbpec_pkg for payload types

interface dbpec_req_if;
    logic               valid;
    logic               ready;
    dbpec_pkg::req_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbpec_rsp_if;
    logic               valid;
    logic               ready;
    dbpec_pkg::rsp_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbpec_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dbpec_pkg::PSIZE_W-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/db_page_endian_converter_core.sv]
// db_page_endian_converter_core: top level, page store plus swap sequencer
// depends on dbpec_pkg and the channel interfaces in dbpec_if
//
// usage: requests arrive on req (func, byte_addr, write_byte); each gives
// exactly one response on rsp (read_byte, status). page_size is written on
// cfg while idle. a write, an unknown func or an oversize convert answers at
// the accepting edge, so its response is valid in the cycle after accept; a
// read answers from S_RDWAIT, after one registered memory read. a convert
// walks the page over one shared byte port, each byte swap being 2 reads plus
// 2 writes. it first swaps the header fields and then checks the page type;
// a page of an unknown type answers as header-only there. otherwise it reads
// the entry count, swaps each offset slot, checks each hash or leaf entry
// and swaps the key or overflow bytes that it finds, swaps each internal
// entry (with its overflow words), and then ends the walk. one request is
// in work at a time: req is not ready while a request is in work or its
// response waits, and the response is held in an output register until
// rsp.ready, so the next request is taken no earlier than the cycle after
// the response leaves. reset clears control and page_size to 4096; the page
// store is not cleared, reading an unwritten byte returns an undefined value.

module db_page_endian_converter_core #(
    parameter int unsigned MAX_PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    dbpec_req_if.sink   req,
    dbpec_rsp_if.source rsp,
    dbpec_cfg_if.sink   cfg
);

    localparam int unsigned MA_W = (MAX_PAGE_BYTES > 1) ? $clog2(MAX_PAGE_BYTES) : 1;
    localparam logic [17:0] MAX_B = 18'(MAX_PAGE_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_RDWAIT,
        S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
        S_HDR, S_TYPE_RD, S_TYPE_CK, S_CNT_RD0, S_CNT_RD1, S_CNT_CK,
        S_SLOT, S_OFF_RD0, S_OFF_RD1, S_OFF_CK, S_ENT_RD, S_ENT_CK,
        S_ENT2_RD, S_ENT2_CK
    } state_t;

    // return codes: where the sequencer goes once a swap group ends
    typedef enum logic [2:0] {
        R_HDR, R_SLOT, R_ENT, R_ENT2, R_NEXT
    } ret_t;

    logic [7:0] mem [MAX_PAGE_BYTES];

    state_t state_reg;
    ret_t   ret_reg;
    logic [dbpec_pkg::PSIZE_W-1:0] psize_reg;
    dbpec_pkg::rsp_t rsp_reg;
    logic rsp_valid_reg;
    logic [17:0] a_reg, b_reg;       // swap byte pair
    logic [7:0]  ta_reg;             // byte held during swap
    logic [3:0]  nsw_reg;            // swaps left in current group
    logic [17:0] base_reg;           // base of current swap group
    logic [2:0]  hstep_reg;          // header group index
    logic [7:0]  type_reg;
    logic [15:0] nent_reg, idx_reg;
    logic [17:0] minoff_reg, off_reg;
    logic [7:0]  lo_reg;
    logic        rvalid_reg;
    logic [7:0]  rdata_reg;

    // memory port: one access per cycle
    logic        m_we, m_re;
    logic [17:0] m_addr;
    logic [7:0]  m_wd;
    logic        m_in;
    assign m_in = (m_addr < MAX_B);

    always_ff @(posedge clk)
    begin
        if (m_we && m_in)
            mem[m_addr[MA_W-1:0]] <= m_wd;
        if (m_re && m_in)
            rdata_reg <= mem[m_addr[MA_W-1:0]];
    end

    // read data with out-of-store reads as zero
    logic [7:0] rd;
    assign rd = rvalid_reg ? rdata_reg : 8'd0;

    logic [17:0] ps18;
    assign ps18 = {1'b0, psize_reg};

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // memory port drive
    always_comb
    begin
        m_we = 1'b0;
        m_re = 1'b0;
        m_addr = 18'd0;
        m_wd = 8'd0;
        case (state_reg)
            S_IDLE:
            begin
                m_addr = {2'b0, req.data.byte_addr};
                m_we = req.valid && req.ready && req.data.func == dbpec_pkg::FUNC_WRITE;
                m_re = req.valid && req.ready && req.data.func == dbpec_pkg::FUNC_READ;
                m_wd = req.data.write_byte;
            end
            S_SW_RA: begin m_re = 1'b1; m_addr = a_reg; end
            S_SW_RB: begin m_re = 1'b1; m_addr = b_reg; end
            S_SW_WA: begin m_we = 1'b1; m_addr = a_reg; m_wd = rd; end
            S_SW_WB: begin m_we = 1'b1; m_addr = b_reg; m_wd = ta_reg; end
            S_TYPE_RD: begin m_re = 1'b1; m_addr = dbpec_pkg::TYPE_POS + 18'd0; end
            S_CNT_RD0: begin m_re = 1'b1; m_addr = 18'd20; end
            S_CNT_RD1: begin m_re = 1'b1; m_addr = 18'd21; end
            S_OFF_RD0: begin m_re = 1'b1; m_addr = base_reg; end
            S_OFF_RD1: begin m_re = 1'b1; m_addr = base_reg + 18'd1; end
            S_ENT_RD:
            begin
                m_re = 1'b1;
                m_addr = (type_reg == dbpec_pkg::T_HASH || type_reg == dbpec_pkg::T_HASH_UNS)
                         ? off_reg : off_reg + 18'd2;
            end
            S_ENT2_RD: begin m_re = 1'b1; m_addr = off_reg + 18'd2; end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            psize_reg     <= dbpec_pkg::PSIZE_RESET;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            rvalid_reg    <= 1'b0;
            ret_reg       <= R_NEXT;
            nsw_reg       <= '0;
            hstep_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            ta_reg        <= '0;
            base_reg      <= '0;
            type_reg      <= '0;
            nent_reg      <= '0;
            idx_reg       <= '0;
            minoff_reg    <= '0;
            off_reg       <= '0;
            lo_reg        <= '0;
        end
        else
        begin
            rvalid_reg <= m_re && m_in;
            if (cfg.valid)
                psize_reg <= cfg.data;
            if (rsp_valid_reg && rsp.ready)
                rsp_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        rsp_reg.read_byte <= '0;
                        if (req.data.func == dbpec_pkg::FUNC_CONVERT && ps18 > MAX_B)
                            rsp_reg.status <= dbpec_pkg::ST_TOO_BIG;
                        else
                            rsp_reg.status <= dbpec_pkg::ST_OK;
                        if (req.data.func == dbpec_pkg::FUNC_READ)
                            state_reg <= S_RDWAIT;
                        else if (req.data.func == dbpec_pkg::FUNC_CONVERT)
                        begin
                            if (ps18 > MAX_B)
                                rsp_valid_reg <= 1'b1;
                            else
                            begin
                                hstep_reg <= 3'd0;
                                state_reg <= S_HDR;
                            end
                        end
                        else
                            rsp_valid_reg <= 1'b1;
                    end
                end
                S_RDWAIT:
                begin
                    rsp_reg.read_byte <= rd;
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                // header groups: 32 at 8, 12, 16, then 16 at 20, 22
                S_HDR:
                begin
                    ret_reg <= R_HDR;
                    hstep_reg <= hstep_reg + 3'd1;
                    case (hstep_reg)
                        3'd0: begin base_reg <= 18'd8;  nsw_reg <= 4'd2; end
                        3'd1: begin base_reg <= 18'd12; nsw_reg <= 4'd2; end
                        3'd2: begin base_reg <= 18'd16; nsw_reg <= 4'd2; end
                        3'd3: begin base_reg <= 18'd20; nsw_reg <= 4'd1; end
                        3'd4: begin base_reg <= 18'd22; nsw_reg <= 4'd1; end
                        default: ;
                    endcase
                    if (hstep_reg == 3'd5)
                        state_reg <= S_TYPE_RD;
                    else
                        state_reg <= S_SW_RA;
                    // first pair of group
                    case (hstep_reg)
                        3'd0: begin a_reg <= 18'd8;  b_reg <= 18'd11; end
                        3'd1: begin a_reg <= 18'd12; b_reg <= 18'd15; end
                        3'd2: begin a_reg <= 18'd16; b_reg <= 18'd19; end
                        3'd3: begin a_reg <= 18'd20; b_reg <= 18'd21; end
                        3'd4: begin a_reg <= 18'd22; b_reg <= 18'd23; end
                        default: ;
                    endcase
                end
                // one byte swap on the shared port
                S_SW_RA: state_reg <= S_SW_RB;
                S_SW_RB:
                begin
                    ta_reg <= rd;
                    state_reg <= S_SW_WA;
                end
                S_SW_WA: state_reg <= S_SW_WB;
                S_SW_WB:
                begin
                    // pattern: 32-bit words pairs (0,3),(1,2); a group of 2 per word
                    if (nsw_reg == 4'd2 || nsw_reg == 4'd4)
                    begin
                        a_reg <= a_reg + 18'd1;
                        b_reg <= b_reg - 18'd1;
                        nsw_reg <= nsw_reg - 4'd1;
                        state_reg <= S_SW_RA;
                    end
                    else if (nsw_reg == 4'd3)
                    begin
                        a_reg <= a_reg + 18'd3;
                        b_reg <= a_reg + 18'd6;
                        nsw_reg <= nsw_reg - 4'd1;
                        state_reg <= S_SW_RA;
                    end
                    else
                    begin
                        case (ret_reg)
                            R_HDR:  state_reg <= S_HDR;
                            R_SLOT: state_reg <= S_OFF_RD0;
                            R_ENT:
                            begin
                                // btree internal: after length, do words
                                if (base_reg == off_reg && type_reg == dbpec_pkg::T_BINT)
                                begin
                                    base_reg <= off_reg + 18'd4;
                                    a_reg <= off_reg + 18'd4;
                                    b_reg <= off_reg + 18'd7;
                                    nsw_reg <= 4'd4;
                                    state_reg <= S_SW_RA;
                                end
                                else if (type_reg == dbpec_pkg::T_BINT)
                                    state_reg <= S_ENT2_RD;
                                else
                                    state_reg <= S_SLOT;
                            end
                            default: state_reg <= S_SLOT;
                        endcase
                    end
                end
                S_TYPE_RD: state_reg <= S_TYPE_CK;
                S_TYPE_CK:
                begin
                    type_reg <= rd;
                    if (rd == dbpec_pkg::T_HASH || rd == dbpec_pkg::T_HASH_UNS ||
                        rd == dbpec_pkg::T_BINT || rd == dbpec_pkg::T_BLEAF)
                        state_reg <= S_CNT_RD0;
                    else
                    begin
                        rsp_reg.status <= dbpec_pkg::ST_HDR_ONLY;
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_CNT_RD0: state_reg <= S_CNT_RD1;
                S_CNT_RD1:
                begin
                    lo_reg <= rd;
                    state_reg <= S_CNT_CK;
                end
                S_CNT_CK:
                begin
                    logic [17:0] lim;
                    logic [15:0] n;
                    lim = (ps18 >= 18'd26) ? ((ps18 - 18'd26) >> 1) : 18'd0;
                    n = {rd, lo_reg};
                    if ({2'b0, n} > lim)
                        n = lim[15:0];
                    nent_reg <= n;
                    minoff_reg <= 18'd26 + {1'b0, n, 1'b0};
                    idx_reg <= 16'd0;
                    state_reg <= S_SLOT;
                end
                // next offset slot
                S_SLOT:
                begin
                    if (idx_reg == nent_reg)
                    begin
                        rsp_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        base_reg <= 18'd26 + {1'b0, idx_reg, 1'b0};
                        a_reg <= 18'd26 + {1'b0, idx_reg, 1'b0};
                        b_reg <= 18'd27 + {1'b0, idx_reg, 1'b0};
                        nsw_reg <= 4'd1;
                        ret_reg <= R_SLOT;
                        idx_reg <= idx_reg + 16'd1;
                        state_reg <= S_SW_RA;
                    end
                end
                S_OFF_RD0: state_reg <= S_OFF_RD1;
                S_OFF_RD1:
                begin
                    lo_reg <= rd;
                    state_reg <= S_OFF_CK;
                end
                S_OFF_CK:
                begin
                    off_reg <= {2'b0, rd, lo_reg};
                    if ({2'b0, rd, lo_reg} < minoff_reg || {2'b0, rd, lo_reg} >= ps18)
                        state_reg <= S_SLOT;
                    else if (type_reg == dbpec_pkg::T_BINT)
                    begin
                        if ({2'b0, rd, lo_reg} + 18'd12 > ps18)
                            state_reg <= S_SLOT;
                        else
                        begin
                            base_reg <= {2'b0, rd, lo_reg};
                            a_reg <= {2'b0, rd, lo_reg};
                            b_reg <= {2'b0, rd, lo_reg} + 18'd1;
                            nsw_reg <= 4'd1;
                            ret_reg <= R_ENT;
                            state_reg <= S_SW_RA;
                        end
                    end
                    else
                        state_reg <= S_ENT_RD;
                end
                S_ENT_RD: state_reg <= S_ENT_CK;
                // hash and leaf entry decision
                S_ENT_CK:
                begin
                    ret_reg <= R_NEXT;
                    base_reg <= off_reg + 18'd4;
                    if (type_reg == dbpec_pkg::T_BLEAF)
                    begin
                        if (off_reg + 18'd3 <= ps18 && rd == dbpec_pkg::K_KEYDATA)
                        begin
                            a_reg <= off_reg;
                            b_reg <= off_reg + 18'd1;
                            nsw_reg <= 4'd1;
                            state_reg <= S_SW_RA;
                        end
                        else if (off_reg + 18'd12 <= ps18 && rd == dbpec_pkg::K_OVERFLOW)
                        begin
                            a_reg <= off_reg + 18'd4;
                            b_reg <= off_reg + 18'd7;
                            nsw_reg <= 4'd4;
                            state_reg <= S_SW_RA;
                        end
                        else
                            state_reg <= S_SLOT;
                    end
                    else if (rd == dbpec_pkg::K_OVERFLOW && off_reg + 18'd12 <= ps18)
                    begin
                        a_reg <= off_reg + 18'd4;
                        b_reg <= off_reg + 18'd7;
                        nsw_reg <= 4'd4;
                        state_reg <= S_SW_RA;
                    end
                    else
                        state_reg <= S_SLOT;
                end
                S_ENT2_RD: state_reg <= S_ENT2_CK;
                // internal entry overflow words
                S_ENT2_CK:
                begin
                    ret_reg <= R_ENT2;
                    if (rd == dbpec_pkg::K_OVERFLOW && off_reg + 18'd24 <= ps18)
                    begin
                        base_reg <= off_reg + 18'd16;
                        a_reg <= off_reg + 18'd16;
                        b_reg <= off_reg + 18'd19;
                        nsw_reg <= 4'd4;
                        state_reg <= S_SW_RA;
                    end
                    else
                        state_reg <= S_SLOT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
